// ----- sv/nearest_road_endpoint_search_top_defines.svh -----
// Assertion macros for the checker file.
`ifndef NEAREST_ROAD_ENDPOINT_SEARCH_TOP_DEFINES_SVH
`define NEAREST_ROAD_ENDPOINT_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define NRES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define NRES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nres_pkg.sv -----
`default_nettype none
package nres_pkg;

  localparam int TILE_W     = 1518;
  localparam int TILE_H     = 1032;
  localparam int SKIP_LIMIT = 20000;
  localparam int RECIP_SH   = 30;

  localparam int QX_W    = 19;
  localparam int COORD_W = 16;
  localparam int ID_W    = 32;
  localparam int LOC_W   = 11;
  localparam int DIST_W  = 31;
  localparam int ABS_W   = 20;
  localparam int TIDX_W  = 16;

  // reciprocals for the query quotient, error of at most one below
  localparam int RECIP_X   = (1 << RECIP_SH) / TILE_W;
  localparam int RECIP_Y   = (1 << RECIP_SH) / TILE_H;
  localparam int RECIP_X_W = $clog2(RECIP_X + 1);
  localparam int RECIP_Y_W = $clog2(RECIP_Y + 1);

  localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(1 << 30);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] OPC_QUERY  = 2'd0;
  localparam logic [1:0] OPC_ROAD   = 2'd1;
  localparam logic [1:0] OPC_FINISH = 2'd2;

  localparam logic KIND_TILE   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    IT_QUERY,
    IT_ROAD,
    IT_FINISH
  } item_kind_t;

  typedef enum logic {
    QS_IDLE,
    QS_MUL
  } qstate_t;

  typedef struct packed {
    item_kind_t                 kind;
    logic [QX_W-1:0]            qx;
    logic [QX_W-1:0]            qy;
    logic signed [COORD_W-1:0]  sx;
    logic signed [COORD_W-1:0]  sy;
    logic signed [COORD_W-1:0]  ex;
    logic signed [COORD_W-1:0]  ey;
    logic [ID_W-1:0]            id;
  } item_t;

endpackage
`default_nettype wire

// ----- sv/nres_front.sv -----
`default_nettype none
module nres_front
  import nres_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic [1:0]                 opcode,
  input  wire logic [QX_W-1:0]            query_x,
  input  wire logic [QX_W-1:0]            query_y,
  input  wire logic signed [COORD_W-1:0]  start_x,
  input  wire logic signed [COORD_W-1:0]  start_y,
  input  wire logic signed [COORD_W-1:0]  end_x,
  input  wire logic signed [COORD_W-1:0]  end_y,
  input  wire logic [ID_W-1:0]            road_id,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output item_t                           push_item
);

  logic  hold_valid;
  item_t hold_item;
  item_t dec;
  logic  keep;

  always_comb begin
    dec.kind = IT_FINISH;
    dec.qx   = query_x;
    dec.qy   = query_y;
    dec.sx   = start_x;
    dec.sy   = start_y;
    dec.ex   = end_x;
    dec.ey   = end_y;
    dec.id   = road_id;
    keep     = 1'b1;
    unique case (opcode)
      OPC_QUERY:  dec.kind = IT_QUERY;
      OPC_ROAD:   dec.kind = IT_ROAD;
      OPC_FINISH: dec.kind = IT_FINISH;
      default:    keep = 1'b0;  // unused opcode: no state change, no result
    endcase
  end

  assign req_ready  = !hold_valid || push_ready;
  assign push_valid = hold_valid;
  assign push_item  = hold_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_ready) begin
      hold_valid <= req_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold_item <= dec;
    end
  end

endmodule
`default_nettype wire

// ----- sv/nres_queue.sv -----
`default_nettype none
module nres_queue
  import nres_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire item_t push_item,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output item_t      pop_item
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = count != (QPTR_W+1)'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- sv/nres_back.sv -----
`default_nettype none
module nres_back
  import nres_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  pop_valid,
  output logic                       pop_ready,
  input  wire item_t                 pop_item,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output logic                       kind,
  output logic [TIDX_W-1:0]          tile_index,
  output logic                       found,
  output logic                       at_start,
  output logic signed [ABS_W-1:0]    near_x,
  output logic signed [ABS_W-1:0]    near_y,
  output logic [ID_W-1:0]            best_id
);

  localparam logic [RECIP_X_W-1:0] RECIP_X_V = RECIP_X_W'(RECIP_X);
  localparam logic [RECIP_Y_W-1:0] RECIP_Y_V = RECIP_Y_W'(RECIP_Y);
  localparam logic [QX_W-1:0]      TILE_W_Q  = QX_W'(TILE_W);
  localparam logic [QX_W-1:0]      TILE_H_Q  = QX_W'(TILE_H);
  localparam logic [ABS_W-1:0]     TILE_W_A  = ABS_W'(TILE_W);
  localparam logic [ABS_W-1:0]     TILE_H_A  = ABS_W'(TILE_H);
  localparam logic [COORD_W-1:0]   SKIP_V    = COORD_W'(SKIP_LIMIT);

  function automatic logic [COORD_W-1:0] mag17(input logic signed [COORD_W:0] d);
    logic signed [COORD_W:0] n;
    n = -d;
    return d[COORD_W] ? n[COORD_W-1:0] : d[COORD_W-1:0];
  endfunction

  // ---------------- stage A: query divide, candidate squares ----------------
  qstate_t qstate, qstate_next;
  logic [QX_W+RECIP_X_W-1:0] prod_x;
  logic [QX_W+RECIP_Y_W-1:0] prod_y;
  logic [LOC_W-1:0]          local_qx;
  logic [LOC_W-1:0]          local_qy;

  logic                      a_load;
  logic                      a_free;

  logic [QX_W-1:0]   qhat_x, qhat_y, rem_x_raw, rem_y_raw, quot_x, quot_y;
  logic [QX_W-1:0]   rem_x, rem_y;
  logic [2*QX_W-1:0] back_x, back_y;
  logic              corr_x, corr_y;
  logic [TIDX_W-1:0] tile_calc;

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic               skip;
  logic [2*COORD_W-1:0] sq_ax, sq_ay, sq_bx, sq_by;

  always_comb begin
    qhat_x    = QX_W'(prod_x >> RECIP_SH);
    qhat_y    = QX_W'(prod_y >> RECIP_SH);
    back_x    = qhat_x * TILE_W_Q;
    back_y    = qhat_y * TILE_H_Q;
    rem_x_raw = pop_item.qx - back_x[QX_W-1:0];
    rem_y_raw = pop_item.qy - back_y[QX_W-1:0];
    corr_x    = rem_x_raw >= TILE_W_Q;
    corr_y    = rem_y_raw >= TILE_H_Q;
    quot_x    = qhat_x + QX_W'(corr_x);
    quot_y    = qhat_y + QX_W'(corr_y);
    rem_x     = corr_x ? rem_x_raw - TILE_W_Q : rem_x_raw;
    rem_y     = corr_y ? rem_y_raw - TILE_H_Q : rem_y_raw;
    tile_calc = TIDX_W'({quot_x, 8'h00} + (QX_W+8)'(quot_y));
  end

  always_comb begin
    ax    = mag17($signed({pop_item.sx[COORD_W-1], pop_item.sx})
                  - $signed({(COORD_W+1-LOC_W)'(0), local_qx}));
    ay    = mag17($signed({pop_item.sy[COORD_W-1], pop_item.sy})
                  - $signed({(COORD_W+1-LOC_W)'(0), local_qy}));
    bx    = mag17($signed({pop_item.ex[COORD_W-1], pop_item.ex})
                  - $signed({(COORD_W+1-LOC_W)'(0), local_qx}));
    by    = mag17($signed({pop_item.ey[COORD_W-1], pop_item.ey})
                  - $signed({(COORD_W+1-LOC_W)'(0), local_qy}));
    skip  = (ax > SKIP_V) || (ay > SKIP_V);
    sq_ax = ax * ax;
    sq_ay = ay * ay;
    sq_bx = bx * bx;
    sq_by = by * by;
  end

  // queries wait in QS_MUL for the registered reciprocal multiply before they leave
  always_comb begin
    qstate_next = qstate;
    pop_ready   = 1'b0;
    a_load      = 1'b0;
    if (pop_valid) begin
      unique case (pop_item.kind)
        IT_QUERY: begin
          if (qstate == QS_IDLE) begin
            qstate_next = QS_MUL;
          end else if (a_free) begin
            qstate_next = QS_IDLE;
            pop_ready   = 1'b1;
            a_load      = 1'b1;
          end
        end
        IT_ROAD: begin
          pop_ready = a_free;
          a_load    = a_free && !skip;
        end
        IT_FINISH: begin
          pop_ready = a_free;
          a_load    = a_free;
        end
        default: pop_ready = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qstate <= QS_IDLE;
    end else begin
      qstate <= qstate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_qx <= '0;
      local_qy <= '0;
    end else if (a_load && pop_item.kind == IT_QUERY) begin
      local_qx <= rem_x[LOC_W-1:0];
      local_qy <= rem_y[LOC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (qstate == QS_IDLE) begin
      prod_x <= pop_item.qx * RECIP_X_V;
      prod_y <= pop_item.qy * RECIP_Y_V;
    end
  end

  // ---------------- A to B register ----------------
  logic                      ab_valid;
  item_kind_t                ab_kind;
  logic [TIDX_W-1:0]         ab_tile;
  logic [DIST_W-1:0]         ab_sq_ax, ab_sq_ay, ab_sq_bx, ab_sq_by;
  logic signed [COORD_W-1:0] ab_sx, ab_sy, ab_ex, ab_ey;
  logic [ID_W-1:0]           ab_id;

  logic out_free;
  logic b_needs_out;
  logic b_go;

  assign out_free    = !res_valid || res_ready;
  assign b_needs_out = ab_kind != IT_ROAD;
  assign b_go        = ab_valid && (!b_needs_out || out_free);
  assign a_free      = !ab_valid || b_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      ab_valid <= 1'b0;
    end else if (a_free) begin
      ab_valid <= a_load;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      ab_kind  <= pop_item.kind;
      ab_tile  <= tile_calc;
      ab_sq_ax <= sq_ax[DIST_W-1:0];
      ab_sq_ay <= sq_ay[DIST_W-1:0];
      ab_sq_bx <= sq_bx[DIST_W-1:0];
      ab_sq_by <= sq_by[DIST_W-1:0];
      ab_sx    <= pop_item.sx;
      ab_sy    <= pop_item.sy;
      ab_ex    <= pop_item.ex;
      ab_ey    <= pop_item.ey;
      ab_id    <= pop_item.id;
    end
  end

  // ---------------- stage B: compare, best update, report ----------------
  logic [DIST_W-1:0]         best_dist;
  logic                      have_best;
  logic                      best_at_start;
  logic signed [COORD_W-1:0] best_px, best_py;
  logic [ID_W-1:0]           best_road;

  logic [DIST_W:0]    d1, d2, t;
  logic               start_wins;
  logic               better;
  logic [ABS_W-1:0]   col_off, row_off, abs_x, abs_y;

  always_comb begin
    d1         = {1'b0, ab_sq_ax} + {1'b0, ab_sq_ay};
    d2         = {1'b0, ab_sq_bx} + {1'b0, ab_sq_by};
    start_wins = !(d2 < d1);
    t          = start_wins ? d1 : d2;
    better     = t < {1'b0, best_dist};
    col_off    = ABS_W'({(ABS_W-8)'(0), best_road[31:24]} * TILE_W_A);
    row_off    = ABS_W'({(ABS_W-8)'(0), best_road[23:16]} * TILE_H_A);
    abs_x      = ABS_W'($signed(best_px)) + col_off;
    abs_y      = ABS_W'($signed(best_py)) + row_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist     <= DIST_INIT;
      have_best     <= 1'b0;
      best_at_start <= 1'b0;
      best_px       <= '0;
      best_py       <= '0;
      best_road     <= '0;
    end else if (b_go) begin
      if (ab_kind == IT_QUERY) begin
        best_dist     <= DIST_INIT;
        have_best     <= 1'b0;
        best_at_start <= 1'b0;
        best_px       <= '0;
        best_py       <= '0;
        best_road     <= '0;
      end else if (ab_kind == IT_ROAD && better) begin
        best_dist     <= t[DIST_W-1:0];
        have_best     <= 1'b1;
        best_at_start <= start_wins;
        best_px       <= start_wins ? ab_sx : ab_ex;
        best_py       <= start_wins ? ab_sy : ab_ey;
        best_road     <= ab_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_go && b_needs_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && b_needs_out) begin
      if (ab_kind == IT_QUERY) begin
        kind       <= KIND_TILE;
        tile_index <= ab_tile;
        found      <= 1'b0;
        at_start   <= 1'b0;
        near_x     <= '0;
        near_y     <= '0;
        best_id    <= '0;
      end else begin
        // nothing found leaves the best registers cleared, so all zero
        kind       <= KIND_SEARCH;
        tile_index <= '0;
        found      <= have_best;
        at_start   <= best_at_start;
        near_x     <= abs_x;
        near_y     <= abs_y;
        best_id    <= best_road;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/nearest_road_endpoint_search_top.sv -----
// Path: front hold register, queue, stage A, A-to-B register, result register.
// Throughput: one candidate or finish per cycle unless the result output stalls; a query
//   holds the execute stage for the reciprocal multiply, then the remainder correction.
// A 4-entry queue between decode and execute absorbs output stalls.
// Reset: synchronous, clears queue, pipeline valids, query point and search state.
`default_nettype none
module nearest_road_endpoint_search_top
  import nres_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       req_valid,
  output logic                            req_ready,
  input  wire logic [1:0]                 opcode,
  input  wire logic [QX_W-1:0]            query_x,
  input  wire logic [QX_W-1:0]            query_y,
  input  wire logic signed [COORD_W-1:0]  start_x,
  input  wire logic signed [COORD_W-1:0]  start_y,
  input  wire logic signed [COORD_W-1:0]  end_x,
  input  wire logic signed [COORD_W-1:0]  end_y,
  input  wire logic [ID_W-1:0]            road_id,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output logic                            kind,
  output logic [TIDX_W-1:0]               tile_index,
  output logic                            found,
  output logic                            at_start,
  output logic signed [ABS_W-1:0]         near_x,
  output logic signed [ABS_W-1:0]         near_y,
  output logic [ID_W-1:0]                 best_id
);

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;

  nres_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .opcode     (opcode),
    .query_x    (query_x),
    .query_y    (query_y),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .road_id    (road_id),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  nres_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  nres_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .kind       (kind),
    .tile_index (tile_index),
    .found      (found),
    .at_start   (at_start),
    .near_x     (near_x),
    .near_y     (near_y),
    .best_id    (best_id)
  );

endmodule
`default_nettype wire

// ----- sv/nres_checker.sv -----
`default_nettype none
`include "nearest_road_endpoint_search_top_defines.svh"
module nres_checker
  import nres_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       res_valid,
  input wire logic                       res_ready,
  input wire logic                       kind,
  input wire logic [TIDX_W-1:0]          tile_index,
  input wire logic                       found,
  input wire logic                       at_start,
  input wire logic signed [ABS_W-1:0]    near_x,
  input wire logic signed [ABS_W-1:0]    near_y,
  input wire logic [ID_W-1:0]            best_id
);

  `NRES_ASSERT_NOW(a_idle_after_reset, $past(rst), !res_valid, "result valid right after reset")

  `NRES_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(kind) && $stable(tile_index) && $stable(best_id) && $stable(near_x) && $stable(near_y), "stalled result changed")

  `NRES_ASSERT_NOW(a_tile_clean, res_valid && kind == KIND_TILE, !found && !at_start && best_id == '0 && near_x == '0 && near_y == '0, "tile answer carries search fields")

  `NRES_ASSERT_NOW(a_search_clean, res_valid && kind == KIND_SEARCH, tile_index == '0 && (found || (!at_start && best_id == '0 && near_x == '0 && near_y == '0)), "empty search answer not zero")

endmodule

bind nearest_road_endpoint_search_top nres_checker u_nres_checker (.*);
`default_nettype wire

// ----- verif/nearest_road_endpoint_search_top_tb.sv -----
`timescale 1ns / 100ps
module nearest_road_endpoint_search_top_tb;
  import nres_pkg::*;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RAND_REQS    = 650;
  localparam int QMAX_X       = 388607;
  localparam int QMAX_Y       = 264191;

  typedef struct packed {
    logic [1:0]                op;
    logic [QX_W-1:0]           qx;
    logic [QX_W-1:0]           qy;
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic [ID_W-1:0]           id;
  } search_req_t;

  typedef struct packed {
    logic              kind;
    logic [TIDX_W-1:0] tile_index;
    logic              found;
    logic              at_start;
    logic [ABS_W-1:0]  near_x;
    logic [ABS_W-1:0]  near_y;
    logic [ID_W-1:0]   best_id;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  logic res_valid;
  logic res_ready = 1'b0;
  search_req_t cur_req = '0;
  logic kind, found, at_start;
  logic [TIDX_W-1:0] tile_index;
  logic signed [ABS_W-1:0] near_x, near_y;
  logic [ID_W-1:0] best_id;

  search_req_t search_reqs[$];
  answer_t due_answers[$];
  logic req_fire = 1'b0;
  int n_total = 1;
  int n_sent = 0;
  int n_accepted = 0;
  int n_real = 0;
  int n_ignored = 0;
  int n_answers = 0;
  int n_found = 0;
  int n_errors = 0;
  int stall_cycles = 0;
  int send_pct = 0;
  int recv_pct = 0;

  // predicted block state
  longint loc_qx, loc_qy;
  longint best_d;
  bit have_best, best_start;
  longint best_px, best_py;
  logic [ID_W-1:0] best_road;

  nearest_road_endpoint_search_top DUT (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .opcode     (cur_req.op),
    .query_x    (cur_req.qx),
    .query_y    (cur_req.qy),
    .start_x    (cur_req.sx),
    .start_y    (cur_req.sy),
    .end_x      (cur_req.ex),
    .end_y      (cur_req.ey),
    .road_id    (cur_req.id),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .kind       (kind),
    .tile_index (tile_index),
    .found      (found),
    .at_start   (at_start),
    .near_x     (near_x),
    .near_y     (near_y),
    .best_id    (best_id)
  );

  initial forever #5 clk = ~clk;

  task automatic clear_search();
    best_d     = longint'(1) << 30;
    have_best  = 1'b0;
    best_start = 1'b0;
    best_px    = 0;
    best_py    = 0;
    best_road  = '0;
  endtask

  task automatic predict_answer(input search_req_t r);
    answer_t a;
    longint sx, sy, ex, ey, ax, ay, bx, by, d1, d2, t, abs_x, abs_y;
    int idx;
    bit start_wins;
    a = '0;
    case (r.op)
      OPC_QUERY: begin
        idx = (int'(r.qx) / TILE_W) * 256 + int'(r.qy) / TILE_H;
        loc_qx = longint'(int'(r.qx) % TILE_W);
        loc_qy = longint'(int'(r.qy) % TILE_H);
        clear_search();
        a.kind = KIND_TILE;
        a.tile_index = TIDX_W'(idx);
        due_answers.push_back(a);
      end
      OPC_ROAD: begin
        sx = longint'($signed(r.sx));
        sy = longint'($signed(r.sy));
        ex = longint'($signed(r.ex));
        ey = longint'($signed(r.ey));
        ax = sx - loc_qx;
        ay = sy - loc_qy;
        bx = ex - loc_qx;
        by = ey - loc_qy;
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        if (bx < 0) bx = -bx;
        if (by < 0) by = -by;
        if (ax <= SKIP_LIMIT && ay <= SKIP_LIMIT) begin
          d1 = ax * ax + ay * ay;
          d2 = bx * bx + by * by;
          start_wins = !(d2 < d1);
          t = start_wins ? d1 : d2;
          // strict compare keeps the earliest road on equal distance
          if (t < best_d) begin
            best_d     = t;
            have_best  = 1'b1;
            best_start = start_wins;
            best_px    = start_wins ? sx : ex;
            best_py    = start_wins ? sy : ey;
            best_road  = r.id;
          end
        end
      end
      OPC_FINISH: begin
        a.kind = KIND_SEARCH;
        if (have_best) begin
          abs_x = best_px + longint'(TILE_W) * longint'(best_road[31:24]);
          abs_y = best_py + longint'(TILE_H) * longint'(best_road[23:16]);
          a.found    = 1'b1;
          a.at_start = best_start;
          a.near_x   = ABS_W'(abs_x);
          a.near_y   = ABS_W'(abs_y);
          a.best_id  = best_road;
          n_found++;
        end
        due_answers.push_back(a);
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  task automatic check_answer();
    answer_t want;
    if (due_answers.size() == 0) begin
      $display("%0t: unexpected answer, kind %0d tile 0x%0h id 0x%0h", $time, kind,
               tile_index, best_id);
      n_errors++;
    end else begin
      want = due_answers.pop_front();
      n_answers++;
      check_field("kind", want.kind, kind);
      check_field("tile_index", want.tile_index, tile_index);
      check_field("found", want.found, found);
      check_field("at_start", want.at_start, at_start);
      check_field("near_x", want.near_x, $unsigned(near_x));
      check_field("near_y", want.near_y, $unsigned(near_y));
      check_field("best_id", want.best_id, best_id);
    end
  endtask

  task automatic add_req(input logic [1:0] op, input int qx, input int qy, input int sx,
                         input int sy, input int ex, input int ey,
                         input logic [ID_W-1:0] id);
    search_req_t r;
    r.op = op;
    r.qx = QX_W'(qx);
    r.qy = QX_W'(qy);
    r.sx = COORD_W'(sx);
    r.sy = COORD_W'(sy);
    r.ex = COORD_W'(ex);
    r.ey = COORD_W'(ey);
    r.id = id;
    search_reqs.push_back(r);
    if (op == OPC_UNUSED) n_ignored++;
    else n_real++;
  endtask

  // fields a request does not use carry random data
  task automatic add_query(input int qx, input int qy);
    add_req(OPC_QUERY, qx, qy, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic add_road(input int sx, input int sy, input int ex, input int ey,
                          input logic [ID_W-1:0] id);
    add_req(OPC_ROAD, $urandom, $urandom, sx, sy, ex, ey, id);
  endtask

  task automatic add_finish();
    add_req(OPC_FINISH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      case (n_sent * 3 / n_total)
        0: begin
          send_pct = 20;
          recv_pct = 47;
        end
        1: begin
          send_pct = 47;
          recv_pct = 20;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      if (!req_valid || req_fire) begin
        if (search_reqs.size() > 0 && $urandom_range(99) >= send_pct) begin
          cur_req <= search_reqs.pop_front();
          req_valid <= 1'b1;
          n_sent++;
        end else begin
          req_valid <= 1'b0;
        end
      end
      res_ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
      stall_cycles <= 0;
      loc_qx = 0;
      loc_qy = 0;
      clear_search();
    end else begin
      req_fire <= req_valid && req_ready;
      if (req_valid && req_ready) begin
        predict_answer(cur_req);
        n_accepted++;
      end
      if (res_valid && res_ready) check_answer();
      if ((req_valid && req_ready) || (res_valid && res_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int qx, qy, lqx, lqy, n, k, spread, rand_goal;
    int sx, sy, ex, ey;
    bit timed_out;
    timed_out = 1'b0;

    // directed: empty search, limits, ties, skips, range extremes
    add_finish();
    add_query(0, 0);
    add_road(SKIP_LIMIT, -SKIP_LIMIT, 32767, 32767, 32'hFFFF_FFFF);
    add_road(SKIP_LIMIT + 1, 0, 0, 0, 32'h1111_1111);
    add_road(0, SKIP_LIMIT + 1, 0, 0, 32'h2222_2222);
    add_road(-32768, 0, 0, 0, 32'h3333_3333);
    add_road(3, 4, -4, 3, 32'h0102_ABCD);
    add_road(5, 0, 0, -5, 32'h0405_0000);
    add_finish();
    add_finish();
    add_req(OPC_UNUSED, QMAX_X, QMAX_Y, 1, 1, 1, 1, 32'h0F0F_0F0F);
    add_query(QMAX_X, QMAX_Y);
    add_road(21517, -18969, 1517, 1031, 32'hFFFF_0000);
    add_road(1517, 1031, 32767, -32768, 32'h0000_0001);
    add_finish();
    add_query(2**19 - 1, 2**19 - 1);
    add_road(-19423, 20031, -32768, -32768, 32'h00FF_0000);
    add_finish();
    add_query(1517, 1031);
    add_road(-18483, 21031, 21517, -18969, 32'h8080_5555);
    add_finish();

    rand_goal = n_real + RAND_REQS;
    sx = 0;
    sy = 0;
    ex = 0;
    ey = 0;
    while (n_real < rand_goal) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(9) == 0) begin
          qx = $urandom_range(2**19 - 1);
          qy = $urandom_range(2**19 - 1);
        end else begin
          qx = $urandom_range(QMAX_X);
          qy = $urandom_range(QMAX_Y);
        end
        add_query(qx, qy);
        lqx = qx % TILE_W;
        lqy = qy % TILE_H;
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) begin
          // now and then resend the last road's points under a new id
          if (k == 0 || $urandom_range(7) != 0) begin
            spread = ($urandom_range(3) == 0) ? 22000 : 300;
            sx = lqx + int'($urandom_range(2 * spread)) - spread;
            sy = lqy + int'($urandom_range(2 * spread)) - spread;
            case ($urandom_range(3))
              0: begin
                ex = 2 * lqx - sx;
                ey = 2 * lqy - sy;
              end
              1: begin
                ex = int'($urandom_range(65535)) - 32768;
                ey = int'($urandom_range(65535)) - 32768;
              end
              default: begin
                ex = lqx + int'($urandom_range(2 * spread)) - spread;
                ey = lqy + int'($urandom_range(2 * spread)) - spread;
              end
            endcase
          end
          add_road(sx, sy, ex, ey, $urandom);
        end
        add_finish();
        if ($urandom_range(4) == 0) add_finish();
      end else begin
        case ($urandom_range(3))
          0: add_query($urandom_range(2**19 - 1), $urandom_range(2**19 - 1));
          1: add_road($urandom, $urandom, $urandom, $urandom, $urandom);
          2: add_finish();
          default: add_req(OPC_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom);
        endcase
      end
    end
    n_total = search_reqs.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(n_accepted == n_total && due_answers.size() == 0)
           && stall_cycles < STALL_LIMIT)
      @(negedge clk);
    if (stall_cycles >= STALL_LIMIT) begin
      timed_out = 1'b1;
      $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
    end else begin
      repeat (DRAIN_CYCLES) @(negedge clk);
    end

    $display("summary: %0d requests sent (%0d with the unused opcode), %0d answers checked",
             n_sent, n_ignored, n_answers);
    $display("summary: %0d searches reported a road, %0d mismatches", n_found, n_errors);
    if (!timed_out && n_errors == 0 && due_answers.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
